/* design/cpt_pkg.sv */
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for the closest point core
// Fixed-point widths, item structs, region codes and small vector helpers.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // coordinate and derived widths
  localparam int CW          = 16;          // Q8.8 coordinate
  localparam int DIMENSIONS  = 3;
  localparam int DFW         = CW + 1;      // coordinate difference
  localparam int DOTW        = 2 * DFW + 2; // dot product, Q20.16
  localparam int PRW         = 2 * DOTW;    // product of two dot products
  localparam int VW          = PRW + 1;     // barycentric term, Q41.32
  localparam int DENW        = VW + 2;      // sum of three barycentric terms
  localparam int NUMW        = DFW + VW + 1;// projection numerator
  localparam int QB          = CW + 2;      // rounded quotient bits
  localparam int RW          = NUMW + 2;    // divider remainder
  localparam int SQW         = 34;          // squared distance, Q18.16
  localparam int SSW         = 2 * DFW + 2; // full squared distance sum

  // queue and front pipeline
  localparam int QUEUE_DEPTH = 8;
  localparam int FRONT_LAT   = 5;
  localparam int OCCW        = $clog2(FRONT_LAT + 1);

  // configuration port
  localparam int CFG_AW      = 3;
  localparam logic CFG_SIMPLEX = 1'b0;

  // simplex sizes
  localparam logic [1:0] SV_POINT   = 2'd1;
  localparam logic [1:0] SV_SEGMENT = 2'd2;
  localparam logic [1:0] SV_TRI     = 2'd3;

  // region codes
  localparam logic [2:0] REG_A    = 3'd0;
  localparam logic [2:0] REG_B    = 3'd1;
  localparam logic [2:0] REG_C    = 3'd2;
  localparam logic [2:0] REG_AB   = 3'd3;
  localparam logic [2:0] REG_AC   = 3'd4;
  localparam logic [2:0] REG_BC   = 3'd5;
  localparam logic [2:0] REG_FACE = 3'd6;

  typedef logic signed [CW-1:0]   crd_t;
  typedef crd_t [2:0]             vec_t;
  typedef logic signed [DFW-1:0]  dif_t;
  typedef dif_t [2:0]             dvec_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [PRW-1:0]  prd_t;
  typedef logic signed [VW-1:0]   wide_t;
  typedef logic signed [DENW-1:0] den_t;

  typedef struct packed {
    crd_t px, py, pz;
    crd_t ax, ay, az;
    crd_t bx, by_coord, bz;
    crd_t cx, cy, cz;
  } in_item_t;

  typedef struct packed {
    crd_t             qx, qy, qz;
    logic [SQW-1:0]   sq_dist;
    logic [2:0]       region;
    logic             degenerate;
  } out_item_t;

  // item handed from the front to the back: Q = base + round((u*x + w*y) / den)
  typedef struct packed {
    vec_t       p;
    vec_t       base;
    dvec_t      u;
    dvec_t      w;
    wide_t      x;
    wide_t      y;
    den_t       den;
    logic [2:0] region;
    logic       degen;
  } qe_t;

  function automatic vec_t ld3(crd_t x, crd_t y, crd_t z);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = (DIMENSIONS > 2) ? z : '0;
    return v;
  endfunction

  function automatic dvec_t vsub(vec_t a, vec_t b);
    dvec_t r;
    for (int i = 0; i < 3; i++) r[i] = DFW'(a[i]) - DFW'(b[i]);
    return r;
  endfunction

  function automatic dot_t dot3(dvec_t u, dvec_t v);
    dot_t s;
    s = '0;
    for (int i = 0; i < 3; i++) s = s + DOTW'(u[i]) * DOTW'(v[i]);
    return s;
  endfunction

endpackage

/* design/cpt_wmul.sv */
// ----------------------------------------------------------------------------
// cpt_wmul: two-stage signed multiplier
// Splits both operands in halves, registers four partial products, then
// registers their shifted sum.
// ----------------------------------------------------------------------------
module cpt_wmul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AL:0]        al_s;
  logic signed [BL:0]        bl_s;
  logic signed [AH-1:0]      ah_s;
  logic signed [BH-1:0]      bh_s;
  logic signed [AL+BL+1:0]   ll_r;
  logic signed [AL+BH:0]     lh_r;
  logic signed [AH+BL:0]     hl_r;
  logic signed [AH+BH-1:0]   hh_r;
  logic signed [PW-1:0]      p_r;

  // low halves are unsigned, high halves carry the sign
  assign al_s = $signed({1'b0, a[AL-1:0]});
  assign bl_s = $signed({1'b0, b[BL-1:0]});
  assign ah_s = $signed(a[AW-1:AL]);
  assign bh_s = $signed(b[BW-1:BL]);

  // partial products
  always_ff @(posedge clk) begin
    ll_r <= al_s * bl_s;
    lh_r <= al_s * bh_s;
    hl_r <= ah_s * bl_s;
    hh_r <= ah_s * bh_s;
  end

  // recombine: low A times high B weighs 2^BL, high A times low B weighs 2^AL
  always_ff @(posedge clk) begin
    p_r <= (PW'(hh_r) <<< (AL + BL)) + (PW'(lh_r) <<< BL) + (PW'(hl_r) <<< AL) + PW'(ll_r);
  end

  assign p = p_r;

endmodule

/* design/cpt_front.sv */
// ----------------------------------------------------------------------------
// cpt_front: classification pipeline
// Forms edge vectors and dot products, the barycentric terms, sorts the
// query point into its region and sets up the projection for the back.
// ----------------------------------------------------------------------------
module cpt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  cpt_pkg::in_item_t           item,
  input  logic [1:0]                  simplex,
  output logic                        push,
  output cpt_pkg::qe_t                push_data,
  output logic [cpt_pkg::OCCW-1:0]    occupancy
);
  import cpt_pkg::*;

  typedef struct packed {
    vec_t  p, a, b, c;
    dvec_t ab, ac, ap, bp, cp, cb;
  } s1_t;

  typedef struct packed {
    vec_t  p, a, b, c;
    dvec_t ab, ac, cb;
    dot_t  d1, d2, d3, d4, d5, d6;
  } fs_t;

  localparam int EW = DOTW + 1;

  logic [FRONT_LAT-1:0] v_r;
  in_item_t             in_r;
  s1_t                  s1_nxt, s1_r;
  fs_t                  s2_nxt, s2_r, s3_r, s4_r;
  prd_t                 m14, m32, m52, m16, m36, m54;
  wide_t                va, vb, vc;
  logic signed [EW-1:0] e1, e2, dd13, dd26;
  den_t                 den_face;
  qe_t                  e;

  // advance item valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_LAT-2:0], accept};
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= item;
    end
  end

  // fold vertices by simplex size, form differences
  always_comb begin
    s1_nxt.p = ld3(in_r.px, in_r.py, in_r.pz);
    s1_nxt.a = ld3(in_r.ax, in_r.ay, in_r.az);
    s1_nxt.b = ld3(in_r.bx, in_r.by_coord, in_r.bz);
    s1_nxt.c = ld3(in_r.cx, in_r.cy, in_r.cz);
    if (simplex <= SV_POINT) begin
      s1_nxt.b = s1_nxt.a;
      s1_nxt.c = s1_nxt.a;
    end else if (simplex == SV_SEGMENT) begin
      s1_nxt.c = s1_nxt.a;
    end
    s1_nxt.ab = vsub(s1_nxt.b, s1_nxt.a);
    s1_nxt.ac = vsub(s1_nxt.c, s1_nxt.a);
    s1_nxt.ap = vsub(s1_nxt.p, s1_nxt.a);
    s1_nxt.bp = vsub(s1_nxt.p, s1_nxt.b);
    s1_nxt.cp = vsub(s1_nxt.p, s1_nxt.c);
    s1_nxt.cb = vsub(s1_nxt.c, s1_nxt.b);
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // dot products
  always_comb begin
    s2_nxt.p  = s1_r.p;
    s2_nxt.a  = s1_r.a;
    s2_nxt.b  = s1_r.b;
    s2_nxt.c  = s1_r.c;
    s2_nxt.ab = s1_r.ab;
    s2_nxt.ac = s1_r.ac;
    s2_nxt.cb = s1_r.cb;
    s2_nxt.d1 = dot3(s1_r.ab, s1_r.ap);
    s2_nxt.d2 = dot3(s1_r.ac, s1_r.ap);
    s2_nxt.d3 = dot3(s1_r.ab, s1_r.bp);
    s2_nxt.d4 = dot3(s1_r.ac, s1_r.bp);
    s2_nxt.d5 = dot3(s1_r.ab, s1_r.cp);
    s2_nxt.d6 = dot3(s1_r.ac, s1_r.cp);
  end

  // hold side data beside the products
  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s2_r;
    s4_r <= s3_r;
  end

  // products of dot products
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m14 (.clk(clk), .a(s2_r.d1), .b(s2_r.d4), .p(m14));
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m32 (.clk(clk), .a(s2_r.d3), .b(s2_r.d2), .p(m32));
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m52 (.clk(clk), .a(s2_r.d5), .b(s2_r.d2), .p(m52));
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m16 (.clk(clk), .a(s2_r.d1), .b(s2_r.d6), .p(m16));
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m36 (.clk(clk), .a(s2_r.d3), .b(s2_r.d6), .p(m36));
  cpt_wmul #(.AW(DOTW), .BW(DOTW)) u_m54 (.clk(clk), .a(s2_r.d5), .b(s2_r.d4), .p(m54));

  // classify and set up the projection
  always_comb begin
    vc       = VW'(m14) - VW'(m32);
    vb       = VW'(m52) - VW'(m16);
    va       = VW'(m36) - VW'(m54);
    e1       = EW'(s4_r.d4) - EW'(s4_r.d3);
    e2       = EW'(s4_r.d5) - EW'(s4_r.d6);
    dd13     = EW'(s4_r.d1) - EW'(s4_r.d3);
    dd26     = EW'(s4_r.d2) - EW'(s4_r.d6);
    den_face = DENW'(va) + DENW'(vb) + DENW'(vc);

    e        = '0;
    e.p      = s4_r.p;
    e.base   = s4_r.a;
    e.den    = DENW'(1);
    priority if (s4_r.d1 <= 0 && s4_r.d2 <= 0) begin
      e.region = REG_A;
    end else if (s4_r.d3 >= 0 && e1 <= 0) begin
      e.region = REG_B;
      e.base   = s4_r.b;
    end else if (dd13 != 0 && vc <= 0 && s4_r.d1 >= 0 && s4_r.d3 <= 0) begin
      e.region = REG_AB;
      e.u      = s4_r.ab;
      e.x      = VW'(s4_r.d1);
      e.den    = DENW'(dd13);
    end else if (s4_r.d6 >= 0 && e2 <= 0) begin
      e.region = REG_C;
      e.base   = s4_r.c;
    end else if (vb <= 0 && s4_r.d2 >= 0 && s4_r.d6 <= 0) begin
      e.region = REG_AC;
      e.u      = s4_r.ac;
      e.x      = VW'(s4_r.d2);
      e.den    = DENW'(dd26);
    end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      e.region = REG_BC;
      e.base   = s4_r.b;
      e.u      = s4_r.cb;
      e.x      = VW'(e1);
      e.den    = DENW'(e1) + DENW'(e2);
    end else begin
      e.region = REG_FACE;
      e.u      = s4_r.ab;
      e.x      = vb;
      e.w      = s4_r.ac;
      e.y      = vc;
      e.den    = den_face;
    end

    // zero denominator: quotient zero; on the face, flag a collinear triangle
    if (e.den == 0) begin
      e.x     = '0;
      e.y     = '0;
      e.den   = DENW'(1);
      e.degen = (e.region == REG_FACE);
    end
  end

  assign push      = v_r[FRONT_LAT-1];
  assign push_data = e;
  assign occupancy = OCCW'($countones(v_r));

endmodule

/* design/cpt_queue.sv */
// ----------------------------------------------------------------------------
// cpt_queue: item queue between front and back
// Circular buffer with a registered head; drains one item per cycle.
// ----------------------------------------------------------------------------
module cpt_queue #(
  parameter int DEPTH = cpt_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cpt_pkg::qe_t                 push_data,
  output logic                         head_valid,
  output cpt_pkg::qe_t                 head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import cpt_pkg::*;

  localparam int PTRW = $clog2(DEPTH);
  localparam int CTW  = $clog2(DEPTH + 1);

  qe_t             mem [DEPTH];
  logic [PTRW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CTW-1:0]  count_r, count_nxt;
  logic            head_valid_r;
  qe_t             head_r;
  logic            pop;

  assign pop = (count_r != '0);

  // advance pointers and fill count
  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (push) begin
      wr_nxt = (wr_r == PTRW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTRW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r         <= '0;
      rd_r         <= '0;
      count_r      <= '0;
      head_valid_r <= 1'b0;
    end else begin
      wr_r         <= wr_nxt;
      rd_r         <= rd_nxt;
      count_r      <= count_nxt;
      head_valid_r <= pop;
    end
  end

  // storage write and registered head read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_r <= mem[rd_r];
    end
  end

  assign head_valid = head_valid_r;
  assign head       = head_r;
  assign count      = count_r;

endmodule

/* design/cpt_back.sv */
// ----------------------------------------------------------------------------
// cpt_back: projection pipeline
// Multiplies out the projection numerators, divides with one quotient bit
// per stage, rounds, and forms the closest point and squared distance.
// ----------------------------------------------------------------------------
module cpt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  cpt_pkg::qe_t         head,
  output logic                 out_valid,
  output cpt_pkg::out_item_t   out_item
);
  import cpt_pkg::*;

  localparam int PUW = DFW + VW;
  localparam int BL  = QB + 6;

  typedef struct packed {
    vec_t       p;
    vec_t       base;
    logic [2:0] region;
    logic       degen;
  } bs_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [RW-1:0]      dd;
    logic [2:0][QB-1:0] q;
    logic [2:0]         neg;
    bs_t                s;
  } dv_t;

  logic [BL-1:0]             bv_r;
  logic signed [PUW-1:0]     pu [3];
  logic signed [PUW-1:0]     pw [3];
  bs_t                       t1_r, t2_r, t3_r;
  den_t                      den1_r, den2_r, den3_r;
  logic signed [NUMW-1:0]    num_r [3];
  dv_t                       dv0_nxt;
  dv_t                       dv_r [QB+1];
  dv_t                       dn [QB];
  vec_t                      q_nxt, q_r;
  bs_t                       qs_r;
  out_item_t                 out_nxt, out_r;
  logic [RW-1:0]             dabs;

  // advance item valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else begin
      bv_r <= {bv_r[BL-2:0], head_valid};
    end
  end

  // numerator products
  for (genvar i = 0; i < 3; i++) begin : g_mul
    cpt_wmul #(.AW(DFW), .BW(VW)) u_mu (.clk(clk), .a(head.u[i]), .b(head.x), .p(pu[i]));
    cpt_wmul #(.AW(DFW), .BW(VW)) u_mw (.clk(clk), .a(head.w[i]), .b(head.y), .p(pw[i]));
  end

  // hold side data beside the products, then sum
  always_ff @(posedge clk) begin
    t1_r   <= '{p: head.p, base: head.base, region: head.region, degen: head.degen};
    den1_r <= head.den;
    t2_r   <= t1_r;
    den2_r <= den1_r;
    t3_r   <= t2_r;
    den3_r <= den2_r;
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= NUMW'(pu[i]) + NUMW'(pw[i]);
    end
  end

  // magnitudes, doubled for round to nearest
  always_comb begin
    dabs       = den3_r[DENW-1] ? (~RW'(den3_r) + 1'b1) : RW'(den3_r);
    dv0_nxt    = '0;
    dv0_nxt.dd = dabs << 1;
    dv0_nxt.s  = t3_r;
    for (int i = 0; i < 3; i++) begin
      dv0_nxt.neg[i] = num_r[i][NUMW-1] ^ den3_r[DENW-1];
      dv0_nxt.rem[i] = ((num_r[i][NUMW-1] ? (~RW'(num_r[i]) + 1'b1) : RW'(num_r[i])) << 1)
                       + dabs;
    end
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= dv0_nxt;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    always_comb begin
      dn[k] = dv_r[k];
      for (int i = 0; i < 3; i++) begin
        if (dv_r[k].rem[i] >= (dv_r[k].dd << SH)) begin
          dn[k].rem[i]   = dv_r[k].rem[i] - (dv_r[k].dd << SH);
          dn[k].q[i][SH] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      dv_r[k+1] <= dn[k];
    end
  end

  // apply sign and add the base point
  always_comb begin
    logic signed [QB:0] off;
    logic signed [QB:0] sum;
    q_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      off = $signed({1'b0, dv_r[QB].q[i]});
      if (dv_r[QB].neg[i]) begin
        off = -off;
      end
      sum      = (QB + 1)'(dv_r[QB].s.base[i]) + off;
      q_nxt[i] = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    qs_r <= dv_r[QB].s;
  end

  // squared distance
  always_comb begin
    logic signed [SSW-1:0] dd;
    logic [SSW-1:0]        acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      dd  = SSW'(DFW'(qs_r.p[i]) - DFW'(q_r[i]));
      acc = acc + SSW'(dd * dd);
    end
    out_nxt.qx         = q_r[0];
    out_nxt.qy         = q_r[1];
    out_nxt.qz         = q_r[2];
    out_nxt.sq_dist    = SQW'(acc);
    out_nxt.region     = qs_r.region;
    out_nxt.degenerate = qs_r.degen;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = bv_r[BL-1];
  assign out_item  = out_r;

endmodule

/* design/closest_point_on_triangle_core.sv */
// ----------------------------------------------------------------------------
// closest_point_on_triangle_core: closest point on a point, segment or triangle
// Sorts a query point into a Voronoi region of the simplex and returns the
// rounded closest point, the squared distance and the region code.
//
//   channel   ports                            handshake
//   input     start, busy, in_item             taken when start && !busy
//   result    out_valid, out_item              one-cycle strobe, no backpressure
//   config    psel, penable, pwrite, paddr,    APB write at access phase,
//             pwdata, prdata, pready           pready tied high
//
// One item per cycle while busy is low; each taken item passes 5 classification
// stages, the queue storage and head register, 3 multiply stages, a magnitude
// register and 18 divider stages (one rounded quotient bit each), then rounding and output.
// busy rises only when queued plus in-flight front items reach the queue depth.
// Synchronous active-low reset clears valids and sets a triangle simplex.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_core #(
  parameter int QUEUE_DEPTH = cpt_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  cpt_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output cpt_pkg::out_item_t           out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpt_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cpt_pkg::*;

  localparam int CTW = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]       simplex_r;
  logic             accept;
  logic             push;
  qe_t              push_data;
  logic [OCCW-1:0]  occ;
  logic             head_valid;
  qe_t              head;
  logic [CTW-1:0]   q_count;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      simplex_r <= SV_TRI;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_SIMPLEX)) begin
      simplex_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_SIMPLEX) ? {30'b0, simplex_r} : '0;
  assign pready = 1'b1;

  // hold off new items when the queue could overflow
  assign busy   = (32'(q_count) + 32'(occ)) >= 32'(QUEUE_DEPTH);
  assign accept = start && !busy;

  cpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .simplex   (simplex_r),
    .push      (push),
    .push_data (push_data),
    .occupancy (occ)
  );

  cpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  cpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

/* design/cpt_checker.sv */
// ----------------------------------------------------------------------------
// cpt_checker: port-level checks for the closest point core
// Watches the result and configuration ports over time.
// ----------------------------------------------------------------------------
module cpt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input cpt_pkg::out_item_t           out_item,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [cpt_pkg::CFG_AW-1:0]   paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import cpt_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // region code stays within the seven regions
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.region <= REG_FACE)
    else $error("region code out of range");

  // a collinear flag only comes with the face region
  a_degen_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |-> out_item.region == REG_FACE)
    else $error("degenerate flag outside face region");

  // a configuration write leaves the read-back value at the written simplex
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[2] == CFG_SIMPLEX
    |=> prdata[1:0] == $past(pwdata[1:0]) || paddr[2] != CFG_SIMPLEX)
    else $error("configuration read-back mismatch");

endmodule

bind closest_point_on_triangle_core cpt_checker u_cpt_checker (.*);
